// ===== hw/rtl/atw_pkg.sv =====
// Shared constants, types and register codes for the asymmetric Tukey window unit.
package atw_pkg;

  localparam int MaxLength    = 1024;
  localparam int CoefFracBits = 15;

  localparam int LenW    = 11;
  localparam int AlphaW  = 16;
  localparam int MidW    = 19;
  localparam int IdxW    = 10;
  localparam int ValW    = 16;
  localparam int N2W     = 13;
  localparam int DW      = 28;
  localparam int RW      = DW + 1;
  localparam int PhW     = 17;
  localparam int QW      = 31;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 19;

  localparam logic [CfgIdxW-1:0] CfgLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTaper  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCenter = 2'd2;

  localparam logic [AlphaW-1:0] AlphaOne = 16'd32768;
  localparam logic [ValW-1:0]   CoefOne  = ValW'(1 << CoefFracBits);

  localparam logic [QW-1:0] Q30One = 31'd1073741824;
  localparam logic [QW-1:0] C1     = 31'd1686629713;
  localparam logic [QW-1:0] C3     = 31'd693598668;
  localparam logic [QW-1:0] C5     = 31'd85569306;
  localparam logic [QW-1:0] C7     = 31'd5026995;
  localparam logic [QW-1:0] C9     = 31'd172272;

  // Words that bypass the taper arithmetic carry their final value here.
  typedef struct packed {
    logic            force_en;
    logic [ValW-1:0] force_val;
    logic            oor;
  } side_t;

endpackage

// ===== hw/rtl/atw_front.sv =====
// Window geometry: folded index, divisor and bypass decisions over three stages.
module atw_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [atw_pkg::IdxW-1:0]   sample_index_i,
  input  logic [atw_pkg::LenW-1:0]   window_length_i,
  input  logic [atw_pkg::AlphaW-1:0] taper_fraction_i,
  input  logic [atw_pkg::MidW-1:0]   center_position_i,
  output logic                       valid_o,
  output logic [atw_pkg::RW-1:0]     rem_o,
  output logic [atw_pkg::DW-1:0]     div_o,
  output atw_pkg::side_t             side_o
);
  import atw_pkg::*;

  // stage 1
  logic [LenW-1:0]   n;
  logic [MidW-1:0]   n128, n256, mid, rest, mm;
  logic [20:0]       n2sum;
  logic [N2W-1:0]    n2c, n2;
  logic [AlphaW-1:0] alpha;
  logic              oor, head;
  side_t             side1;

  logic              v1_q;
  logic [IdxW-1:0]   j1_q;
  logic [LenW-1:0]   n1_q;
  logic [N2W-1:0]    n21_q;
  logic              head1_q;
  logic [AlphaW-1:0] alpha1_q;
  side_t             side1_q;

  always_comb begin
    n     = (window_length_i > LenW'(MaxLength)) ? LenW'(MaxLength) : window_length_i;
    oor   = {1'b0, sample_index_i} >= n;
    alpha = (taper_fraction_i == '0 || taper_fraction_i > AlphaOne) ? AlphaOne
                                                                    : taper_fraction_i;
    n128  = MidW'({n, 7'b0});
    n256  = MidW'({n, 8'b0});
    mid   = (center_position_i == '0) ? n128 : center_position_i;
    rest  = (n256 > mid) ? n256 - mid : '0;
    mm    = (mid > rest) ? mid : rest;
    n2sum = {1'b0, mm, 1'b0} + 21'd128;
    n2c   = n2sum[20:8];
    n2    = (n2c < N2W'(n)) ? N2W'(n) : n2c;
    head  = mid >= n128;
    side1.oor = oor;
    if (oor) begin
      side1.force_en  = 1'b1;
      side1.force_val = '0;
    end else if (n < LenW'(3)) begin
      side1.force_en  = 1'b1;
      side1.force_val = CoefOne;
    end else begin
      side1.force_en  = 1'b0;
      side1.force_val = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      j1_q     <= sample_index_i;
      n1_q     <= n;
      n21_q    <= n2;
      head1_q  <= head;
      alpha1_q <= alpha;
      side1_q  <= side1;
    end
  end

  // stage 2
  logic [N2W-1:0] k, kb, kf, n2m1;
  logic [28:0]    prod;

  logic           v2_q;
  logic [N2W-1:0] kf2_q;
  logic [DW-1:0]  d2_q;
  side_t          side2_q;

  always_comb begin
    n2m1 = n21_q - N2W'(1);
    k    = head1_q ? N2W'(j1_q) : N2W'(j1_q) + n21_q - N2W'(n1_q);
    kb   = n2m1 - k;
    kf   = (k < kb) ? k : kb;
    prod = {13'b0, alpha1_q} * {16'b0, n2m1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kf2_q   <= kf;
      d2_q    <= prod[DW-1:0];
      side2_q <= side1_q;
    end
  end

  // stage 3: points beyond the taper are flat at one.
  logic  flat;
  side_t side3;

  always_comb begin
    flat  = {kf2_q, 16'b0} > {1'b0, d2_q};
    side3 = side2_q;
    if (flat && !side2_q.force_en) begin
      side3.force_en  = 1'b1;
      side3.force_val = CoefOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= RW'({kf2_q, 15'b0});
      div_o  <= d2_q;
      side_o <= side3;
    end
  end

endmodule

// ===== hw/rtl/atw_div.sv =====
// Pipelined restoring divider giving the taper phase, one quotient bit per stage.
module atw_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [atw_pkg::RW-1:0] rem_i,
  input  logic [atw_pkg::DW-1:0] div_i,
  input  atw_pkg::side_t         side_i,
  output logic                   valid_o,
  output logic [atw_pkg::PhW-1:0] phase_o,
  output atw_pkg::side_t         side_o
);
  import atw_pkg::*;

  logic [PhW-1:0]  v_q;
  logic [RW-1:0]   r_q    [PhW];
  logic [DW-1:0]   d_q    [PhW];
  logic [PhW-1:0]  q_q    [PhW];
  side_t           side_q [PhW];

  for (genvar i = 0; i < PhW; i++) begin : g_step
    logic [RW-1:0]  r_in, r_sh;
    logic [DW-1:0]  d_in;
    logic [PhW-1:0] q_in;
    side_t          s_in;
    logic           v_in, ge;

    if (i == 0) begin : g_first
      assign r_in = rem_i;
      assign d_in = div_i;
      assign q_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign d_in = d_q[i-1];
      assign q_in = q_q[i-1];
      assign s_in = side_q[i-1];
      assign v_in = v_q[i-1];
    end

    assign r_sh = {r_in[RW-2:0], 1'b0};
    assign ge   = r_sh >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i]    <= ge ? r_sh - {1'b0, d_in} : r_sh;
        d_q[i]    <= d_in;
        q_q[i]    <= {q_in[PhW-2:0], ge};
        side_q[i] <= s_in;
      end
    end
  end

  assign valid_o = v_q[PhW-1];
  assign phase_o = q_q[PhW-1];
  assign side_o  = side_q[PhW-1];

endmodule

// ===== hw/rtl/atw_poly.sv =====
// Sine-squared evaluation by a pipelined Horner polynomial, ending in the output register.
module atw_poly (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [atw_pkg::PhW-1:0]  phase_i,
  input  atw_pkg::side_t           side_i,
  output logic                     valid_o,
  output logic [atw_pkg::ValW-1:0] value_o,
  output logic                     oor_o
);
  import atw_pkg::*;

  localparam int HornSteps = 4;
  localparam logic [QW-1:0] HornCoef [HornSteps] = '{C7, C5, C3, C1};

  function automatic logic [QW-1:0] mul_sub(logic [QW-1:0] c, logic [QW-1:0] u,
                                            logic [QW-1:0] t);
    logic [2*QW-1:0] p;
    p = {{QW{1'b0}}, u} * {{QW{1'b0}}, t};
    return c - p[2*QW-2:30];
  endfunction

  // square of the phase gives u in Q30
  logic [33:0]    sq;
  logic           vu_q;
  logic [QW-1:0]  u_q;
  logic [PhW-1:0] phu_q;
  side_t          sideu_q;

  assign sq = {17'b0, phase_i} * {17'b0, phase_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vu_q <= 1'b0;
    end else if (en_i) begin
      vu_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= sq[32:2];
      phu_q   <= phase_i;
      sideu_q <= side_i;
    end
  end

  logic [HornSteps-1:0] vh_q;
  logic [QW-1:0]        uh_q  [HornSteps];
  logic [QW-1:0]        th_q  [HornSteps];
  logic [PhW-1:0]       phh_q [HornSteps];
  side_t                sh_q  [HornSteps];

  for (genvar i = 0; i < HornSteps; i++) begin : g_horn
    logic [QW-1:0]  u_in, t_in;
    logic [PhW-1:0] ph_in;
    side_t          s_in;
    logic           v_in;

    if (i == 0) begin : g_first
      assign u_in  = u_q;
      assign t_in  = C9;
      assign ph_in = phu_q;
      assign s_in  = sideu_q;
      assign v_in  = vu_q;
    end else begin : g_next
      assign u_in  = uh_q[i-1];
      assign t_in  = th_q[i-1];
      assign ph_in = phh_q[i-1];
      assign s_in  = sh_q[i-1];
      assign v_in  = vh_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vh_q[i] <= 1'b0;
      end else if (en_i) begin
        vh_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        uh_q[i]  <= u_in;
        th_q[i]  <= mul_sub(HornCoef[i], u_in, t_in);
        phh_q[i] <= ph_in;
        sh_q[i]  <= s_in;
      end
    end
  end

  // final odd factor: s = x * t, with x = phase << 14
  logic [47:0]   sp;
  logic [QW-1:0] s_d, s_q;
  logic          vs_q;
  side_t         sides_q;

  always_comb begin
    sp  = {31'b0, phh_q[HornSteps-1]} * {17'b0, th_q[HornSteps-1]};
    s_d = (sp[47:16] > {1'b0, Q30One}) ? Q30One : sp[46:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en_i) begin
      vs_q <= vh_q[HornSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= s_d;
      sides_q <= sh_q[HornSteps-1];
    end
  end

  // square and round half up into the coefficient format
  logic [2*QW-1:0] ss, vsum, vsh;
  logic [ValW-1:0] v_d;

  always_comb begin
    ss   = {{QW{1'b0}}, s_q} * {{QW{1'b0}}, s_q};
    vsum = ss + (62'd1 << (59 - CoefFracBits));
    vsh  = vsum >> (60 - CoefFracBits);
    if (sides_q.force_en) begin
      v_d = sides_q.force_val;
    end else if (vsh > 62'(CoefOne)) begin
      v_d = CoefOne;
    end else begin
      v_d = vsh[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_o <= v_d;
      oor_o   <= sides_q.oor;
    end
  end

endmodule

// ===== hw/rtl/asymmetric_tukey_window_unit.sv =====
// Asymmetric Tukey window unit: one sample index per cycle in, one coefficient per cycle out,
// passing through three geometry stages, seventeen divider stages (one
// quotient bit of the taper phase each) and seven polynomial stages, the last being the output
// register. All stages advance together; a stall on a valid output holds the whole pipeline and
// is passed straight back to the input. Configuration words are taken in any cycle.
module asymmetric_tukey_window_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [atw_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [atw_pkg::IdxW-1:0]      sample_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [atw_pkg::ValW-1:0]      window_value_o,
  output logic                          index_out_of_range_o
);
  import atw_pkg::*;

  logic [LenW-1:0]   window_length_q;
  logic [AlphaW-1:0] taper_fraction_q;
  logic [MidW-1:0]   center_position_q;
  logic              en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q   <= '0;
      taper_fraction_q  <= AlphaOne;
      center_position_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLength: window_length_q   <= cfg_wdata_i[LenW-1:0];
        CfgTaper:  taper_fraction_q  <= cfg_wdata_i[AlphaW-1:0];
        CfgCenter: center_position_q <= cfg_wdata_i[MidW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished word is waiting on a stalled output.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic            fr_valid, dv_valid;
  logic [RW-1:0]   fr_rem;
  logic [DW-1:0]   fr_div;
  side_t           fr_side, dv_side;
  logic [PhW-1:0]  dv_phase;

  atw_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_valid_i),
    .sample_index_i    (sample_index_i),
    .window_length_i   (window_length_q),
    .taper_fraction_i  (taper_fraction_q),
    .center_position_i (center_position_q),
    .valid_o           (fr_valid),
    .rem_o             (fr_rem),
    .div_o             (fr_div),
    .side_o            (fr_side)
  );

  atw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rem_i   (fr_rem),
    .div_i   (fr_div),
    .side_i  (fr_side),
    .valid_o (dv_valid),
    .phase_o (dv_phase),
    .side_o  (dv_side)
  );

  atw_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .phase_i (dv_phase),
    .side_i  (dv_side),
    .valid_o (out_valid_o),
    .value_o (window_value_o),
    .oor_o   (index_out_of_range_o)
  );

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_out_of_range_o |-> window_value_o == '0)
    else $error("out-of-range word carries a non-zero coefficient");

  a_value_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_value_o <= CoefOne)
    else $error("coefficient above one");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while the output is held");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_phase) && $stable(fr_rem))
    else $error("pipeline moved during a stall");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the asymmetric Tukey window unit.
module testbench;
  import atw_pkg::*;

  localparam int Latency = 27;
  localparam int WatchdogLimit = 20000;

  // Holds expected coefficient words and compares accepted outputs with them.
  class coef_scoreboard;
    logic [ValW-1:0] exp_val[$];
    logic            exp_oor[$];
    int              errors;
    logic [LenW-1:0]   len;
    logic [AlphaW-1:0] alpha;
    logic [MidW-1:0]   mid;

    function new();
      errors = 0;
      len = '0;
      alpha = AlphaOne;
      mid = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CfgLength) len = data[LenW-1:0];
      else if (idx == CfgTaper) alpha = data[AlphaW-1:0];
      else if (idx == CfgCenter) mid = data[MidW-1:0];
    endfunction

    function logic [63:0] sin_squared(logic [63:0] ph);
      logic [63:0] x, u, t, s, v;
      x = ph << 14;
      u = (x * x) >> 30;
      t = 64'(C7) - ((u * 64'(C9)) >> 30);
      t = 64'(C5) - ((u * t) >> 30);
      t = 64'(C3) - ((u * t) >> 30);
      t = 64'(C1) - ((u * t) >> 30);
      s = (x * t) >> 30;
      if (s > 64'(Q30One)) s = 64'(Q30One);
      v = (s * s + (64'd1 << (59 - CoefFracBits))) >> (60 - CoefFracBits);
      if (v > 64'(CoefOne)) v = 64'(CoefOne);
      return v;
    endfunction

    function void note_index(logic [IdxW-1:0] idx);
      logic [63:0] n, a, m, rest, mm, n2, k, kf, d, v;
      n = len;
      if (n > MaxLength) n = MaxLength;
      if (idx >= n) begin
        exp_val.push_back('0);
        exp_oor.push_back(1'b1);
        return;
      end
      if (n < 3) begin
        exp_val.push_back(CoefOne);
        exp_oor.push_back(1'b0);
        return;
      end
      a = alpha;
      if (a == 0 || a > 32768) a = 32768;
      m = mid;
      if (m == 0) m = n * 128;
      rest = (n * 256 > m) ? n * 256 - m : 0;
      mm = (m > rest) ? m : rest;
      n2 = (2 * mm + 128) >> 8;
      if (n2 < n) n2 = n;
      k = (m >= n * 128) ? 64'(idx) : 64'(idx) + (n2 - n);
      kf = n2 - 1 - k;
      if (k < kf) kf = k;
      d = a * (n2 - 1);
      if ((kf << 16) <= d) v = sin_squared((kf << 32) / d);
      else v = CoefOne;
      exp_val.push_back(v[ValW-1:0]);
      exp_oor.push_back(1'b0);
    endfunction

    function void check_word(logic [ValW-1:0] val, logic oor);
      logic [ValW-1:0] ev;
      logic eo;
      if (exp_val.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word: value %0d flag %0d", val, oor);
        return;
      end
      ev = exp_val.pop_front();
      eo = exp_oor.pop_front();
      if (ev !== val || eo !== oor) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %0d flag %0d, got value %0d flag %0d",
                   ev, eo, val, oor);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [IdxW-1:0] sample_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ValW-1:0] window_value_o;
  logic index_out_of_range_o;

  coef_scoreboard sb = new();
  int idle_cycles = 0;
  bit long_stall_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  asymmetric_tukey_window_unit dut (.*);

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Output side: random stalls and checking of each accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_word(window_value_o, index_out_of_range_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (long_stall_mode) out_stall_i <= ($urandom_range(0, 9) != 0);
      else if (!out_stall_i && $urandom_range(0, 3) == 0) out_stall_i <= 1'b1;
      else if (out_stall_i && $urandom_range(0, 2) != 0) out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("** asymmetric_tukey_window_unit: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic send_index(logic [IdxW-1:0] idx, bit no_gap);
    int g;
    in_valid_i <= 1'b1;
    sample_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_index(idx);
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Waits for all expected words, then lets the pipeline settle before a register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.exp_val.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic setup(logic [CfgW-1:0] n, logic [CfgW-1:0] a, logic [CfgW-1:0] m);
    drain();
    write_reg(CfgLength, n);
    write_reg(CfgTaper, a);
    write_reg(CfgCenter, m);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int n, nph, burst;
    logic [IdxW-1:0] idx;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (empty window), short windows, extremes.
    send_index(10'd0, 0);
    send_index(10'd1023, 0);
    setup(19'd2, 19'd0, 19'd0);
    send_index(10'd0, 0);
    send_index(10'd1, 0);
    send_index(10'd2, 0);
    setup(19'd1024, 19'd32768, 19'd0);
    send_index(10'd0, 1);
    send_index(10'd511, 1);
    send_index(10'd512, 1);
    send_index(10'd1023, 0);
    setup(19'd2047, 19'd65535, 19'h7FFFF);
    send_index(10'd0, 0);
    send_index(10'd1023, 0);
    setup(19'd100, 19'd8192, 19'd5000);
    send_index(10'd0, 0);
    send_index(10'd50, 0);
    send_index(10'd99, 0);
    send_index(10'd100, 0);
    setup(19'd3, 19'd1, 19'd256);
    send_index(10'd0, 0);
    send_index(10'd1, 0);
    send_index(10'd2, 0);
    setup(19'd64, 19'd16384, 19'd30000);
    send_index(10'd0, 0);
    send_index(10'd63, 0);

    // Random phases, mostly in-range indices with a few beyond the length.
    for (nph = 0; nph < 40; nph++) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(3, 1024);
      setup(CfgW'(n),
            CfgW'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 32768)),
            CfgW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 19'h7FFFF)
                                              : $urandom_range(0, n * 512)));
      long_stall_mode = $urandom_range(0, 3) == 0;
      burst = $urandom_range(0, 1);
      for (int i = 0; i < 48; i++) begin
        if ($urandom_range(0, 9) == 0 || n == 0) idx = IdxW'($urandom_range(0, 1023));
        else idx = IdxW'($urandom_range(0, (n > 1024 ? 1024 : n) - 1));
        send_index(idx, burst);
      end
    end
    long_stall_mode = 0;

    drain();
    if (sb.errors == 0)
      $display("** asymmetric_tukey_window_unit: PASSED **");
    else
      $display("** asymmetric_tukey_window_unit: FAILED **");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/atw_pkg.sv
hw/rtl/atw_front.sv
hw/rtl/atw_div.sv
hw/rtl/atw_poly.sv
hw/rtl/asymmetric_tukey_window_unit.sv
tb/testbench.sv
